>>> hdl/irpdt_pkg.sv
// ============================================================================
// irpdt_pkg
// Types and constants shared by the infrared pulse-distance transmitter.
// ============================================================================
`default_nettype none

package irpdt_pkg;

    localparam int FRAME_W    = 64;
    localparam int COUNT_W    = 7;
    localparam int HALF_W     = 8;
    localparam int DUR_W      = 16;
    localparam int ELAPSED_W  = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_START = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CARRIER_HALF = 3'd0,
        CFG_LEADER_MARK  = 3'd1,
        CFG_LEADER_SPACE = 3'd2,
        CFG_ONE_MARK     = 3'd3,
        CFG_ONE_SPACE    = 3'd4,
        CFG_ZERO_MARK    = 3'd5,
        CFG_ZERO_SPACE   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic               kind;
        logic [FRAME_W-1:0] frame_bits;
        logic [COUNT_W-1:0] bit_count;
    } t_in_req;

    typedef struct packed {
        logic pin_level;
        logic busy_res;
        logic frame_done;
    } t_out_res;

    typedef struct packed {
        logic [HALF_W-1:0] carrier_half_us;
        logic [DUR_W-1:0]  leader_mark_us;
        logic [DUR_W-1:0]  leader_space_us;
        logic [DUR_W-1:0]  one_mark_us;
        logic [DUR_W-1:0]  one_space_us;
        logic [DUR_W-1:0]  zero_mark_us;
        logic [DUR_W-1:0]  zero_space_us;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        carrier_half_us: 8'd13,
        leader_mark_us:  16'd9000,
        leader_space_us: 16'd4500,
        one_mark_us:     16'd560,
        one_space_us:    16'd1690,
        zero_mark_us:    16'd560,
        zero_space_us:   16'd560
    };

endpackage

`default_nettype wire

>>> hdl/ir_pulse_distance_transmitter.sv
// ============================================================================
// ir_pulse_distance_transmitter
// Infrared pulse-distance frame transmitter driven by one-microsecond ticks.
// Requests pass through the input register, then the sequencer step writes
// each result to the result register; output back-pressure stalls both.
// Throughput: one request per cycle when not stalled (single-pass sequencer).
// Reset (synchronous, active low): the sequencer goes idle, the timing
// registers return to their defaults and the input and result registers empty.
// ============================================================================
`default_nettype none

module ir_pulse_distance_transmitter #(
    parameter int MAX_BITS = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [irpdt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [irpdt_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  irpdt_pkg::t_in_req                   i_in_req,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output irpdt_pkg::t_out_res                  o_out_res
);

    irpdt_pkg::t_cfg    r_cfg;
    logic               r_in_valid;
    irpdt_pkg::t_in_req r_in_req;
    logic               core_ready;

    assign o_in_ready = !r_in_valid || core_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg      <= irpdt_pkg::CFG_RESET;
            r_in_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    irpdt_pkg::CFG_CARRIER_HALF: begin
                        r_cfg.carrier_half_us <= i_cfg_data[irpdt_pkg::HALF_W-1:0];
                    end
                    irpdt_pkg::CFG_LEADER_MARK:  r_cfg.leader_mark_us  <= i_cfg_data;
                    irpdt_pkg::CFG_LEADER_SPACE: r_cfg.leader_space_us <= i_cfg_data;
                    irpdt_pkg::CFG_ONE_MARK:     r_cfg.one_mark_us     <= i_cfg_data;
                    irpdt_pkg::CFG_ONE_SPACE:    r_cfg.one_space_us    <= i_cfg_data;
                    irpdt_pkg::CFG_ZERO_MARK:    r_cfg.zero_mark_us    <= i_cfg_data;
                    irpdt_pkg::CFG_ZERO_SPACE:   r_cfg.zero_space_us   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
                r_in_req   <= i_in_req;
            end else if (core_ready) begin
                r_in_valid <= 1'b0;
            end
        end
    end

    irpdt_core #(
        .MAX_BITS(MAX_BITS)
    ) u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (r_cfg),
        .i_valid(r_in_valid),
        .o_ready(core_ready),
        .i_req  (r_in_req),
        .o_valid(o_out_valid),
        .i_ready(i_out_ready),
        .o_res  (o_out_res)
    );

endmodule

`default_nettype wire

>>> hdl/irpdt_search.sv
// ============================================================================
// irpdt_search
// Finds the next frame bit that has a segment of nonzero length.
// ============================================================================
`default_nettype none

module irpdt_search #(
    parameter int MAX_BITS = 64
) (
    input  logic [MAX_BITS-1:0]         i_data,
    input  logic [MAX_BITS-1:0]         i_mask,
    input  logic                        i_skip_one,
    input  logic                        i_skip_zero,
    output logic                        o_found,
    output logic [$clog2(MAX_BITS)-1:0] o_pos,
    output logic [MAX_BITS-1:0]         o_rest
);

    localparam int POS_W = $clog2(MAX_BITS);
    localparam int PW    = 1 << POS_W;

    logic [MAX_BITS-1:0] live;
    logic [PW-1:0]       work;
    logic [POS_W-1:0]    lzc;

    always_comb begin
        for (int i = 0; i < MAX_BITS; i++) begin
            live[i] = i_mask[i] & ~(i_data[i] ? i_skip_one : i_skip_zero);
        end
        work = PW'(live);
        lzc  = '0;
        for (int l = POS_W - 1; l >= 0; l--) begin
            if ((work & ({PW{1'b1}} << (PW - (1 << l)))) == '0) begin
                work   = work << (1 << l);
                lzc[l] = 1'b1;
            end
        end
        o_pos   = ~lzc;
        o_found = |live;
        for (int i = 0; i < MAX_BITS; i++) begin
            o_rest[i] = i_mask[i] & (POS_W'(i) < o_pos);
        end
    end

endmodule

`default_nettype wire

>>> hdl/irpdt_core.sv
// ============================================================================
// irpdt_core
// Frame sequencer: segment timing, carrier generation and the result register.
// ============================================================================
`default_nettype none

module irpdt_core #(
    parameter int MAX_BITS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  irpdt_pkg::t_cfg    i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  irpdt_pkg::t_in_req i_req,
    output logic               o_valid,
    input  logic               i_ready,
    output irpdt_pkg::t_out_res o_res
);

    localparam int POS_W = $clog2(MAX_BITS);
    localparam int CW    = irpdt_pkg::COUNT_W;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD_MARK,
        PH_LEAD_SPACE,
        PH_BIT_MARK,
        PH_BIT_SPACE
    } t_phase;

    t_phase                             r_phase, n_phase;
    logic [MAX_BITS-1:0]                r_data, n_data;
    logic [MAX_BITS-1:0]                r_rest, n_rest;
    logic [POS_W-1:0]                   r_pos, n_pos;
    logic [irpdt_pkg::ELAPSED_W-1:0]    r_elapsed, n_elapsed;
    logic [irpdt_pkg::HALF_W-1:0]       r_car_cnt, n_car_cnt;
    logic                               r_car_high, n_car_high;
    logic                               r_out_valid;
    irpdt_pkg::t_out_res                r_res, n_res;

    logic                               take;
    logic                               is_start;
    logic [CW-1:0]                      n_sat;
    logic [MAX_BITS-1:0]                start_mask;
    logic [MAX_BITS-1:0]                start_data;
    logic [MAX_BITS-1:0]                srch_data;
    logic [MAX_BITS-1:0]                srch_mask;
    logic                               srch_found;
    logic [POS_W-1:0]                   srch_pos;
    logic [MAX_BITS-1:0]                srch_rest;
    logic                               skip_one;
    logic                               skip_zero;
    logic                               cur_bit;
    logic                               found_bit;
    logic [irpdt_pkg::HALF_W-1:0]       half;
    logic [irpdt_pkg::DUR_W-1:0]        seg_len;
    logic [irpdt_pkg::DUR_W-1:0]        cur_space;
    logic [irpdt_pkg::DUR_W-1:0]        found_mark;
    logic [irpdt_pkg::HALF_W:0]         car_sum;
    logic [irpdt_pkg::ELAPSED_W-1:0]    elapsed_inc;
    logic [irpdt_pkg::HALF_W-1:0]       car_cnt_inc;
    logic                               car_high_inc;
    logic                               seg_end;
    logic                               jump;
    logic                               pin;

    assign o_ready  = !r_out_valid || i_ready;
    assign take     = i_valid && o_ready;
    assign o_valid  = r_out_valid;
    assign o_res    = r_res;
    assign is_start = (i_req.kind == irpdt_pkg::KIND_START);

    assign n_sat = (i_req.bit_count > CW'(MAX_BITS)) ? CW'(MAX_BITS) : i_req.bit_count;
    assign start_data = i_req.frame_bits[irpdt_pkg::FRAME_W-1 -: MAX_BITS];

    always_comb begin
        for (int i = 0; i < MAX_BITS; i++) begin
            start_mask[i] = ((CW + 1)'(i) + {1'b0, n_sat}) >= (CW + 1)'(MAX_BITS);
        end
    end

    assign skip_one  = (i_cfg.one_mark_us == '0) && (i_cfg.one_space_us == '0);
    assign skip_zero = (i_cfg.zero_mark_us == '0) && (i_cfg.zero_space_us == '0);
    assign srch_data = is_start ? start_data : r_data;
    assign srch_mask = is_start ? start_mask : r_rest;

    irpdt_search #(
        .MAX_BITS(MAX_BITS)
    ) u_search (
        .i_data     (srch_data),
        .i_mask     (srch_mask),
        .i_skip_one (skip_one),
        .i_skip_zero(skip_zero),
        .o_found    (srch_found),
        .o_pos      (srch_pos),
        .o_rest     (srch_rest)
    );

    assign cur_bit    = r_data[r_pos];
    assign found_bit  = srch_data[srch_pos];
    assign cur_space  = cur_bit ? i_cfg.one_space_us : i_cfg.zero_space_us;
    assign found_mark = found_bit ? i_cfg.one_mark_us : i_cfg.zero_mark_us;
    assign half       = (i_cfg.carrier_half_us == '0) ? irpdt_pkg::HALF_W'(1)
                                                      : i_cfg.carrier_half_us;

    always_comb begin
        case (r_phase)
            PH_LEAD_MARK:  seg_len = i_cfg.leader_mark_us;
            PH_LEAD_SPACE: seg_len = i_cfg.leader_space_us;
            PH_BIT_MARK:   seg_len = cur_bit ? i_cfg.one_mark_us : i_cfg.zero_mark_us;
            PH_BIT_SPACE:  seg_len = cur_space;
            default:       seg_len = '0;
        endcase
    end

    always_comb begin
        car_sum      = {1'b0, r_car_cnt} + 1'b1;
        car_cnt_inc  = car_sum[irpdt_pkg::HALF_W-1:0];
        car_high_inc = r_car_high;
        if (car_sum >= {1'b0, half}) begin
            car_cnt_inc  = '0;
            car_high_inc = ~r_car_high;
        end
        elapsed_inc = r_elapsed + 1'b1;
    end

    always_comb begin
        n_phase    = r_phase;
        n_data     = r_data;
        n_rest     = r_rest;
        n_pos      = r_pos;
        n_elapsed  = r_elapsed;
        n_car_cnt  = r_car_cnt;
        n_car_high = r_car_high;
        pin        = 1'b1;
        seg_end    = 1'b0;
        jump       = 1'b0;
        if (is_start) begin
            if (r_phase == PH_IDLE) begin
                n_data     = start_data;
                n_rest     = start_mask;
                n_elapsed  = '0;
                n_car_cnt  = '0;
                n_car_high = 1'b0;
                if (i_cfg.leader_mark_us != '0) begin
                    n_phase = PH_LEAD_MARK;
                end else if (i_cfg.leader_space_us != '0) begin
                    n_phase = PH_LEAD_SPACE;
                end else begin
                    jump = 1'b1;
                end
            end
        end else if (r_phase != PH_IDLE) begin
            n_elapsed = elapsed_inc;
            if (r_phase == PH_LEAD_MARK || r_phase == PH_BIT_MARK) begin
                pin        = r_car_high;
                n_car_cnt  = car_cnt_inc;
                n_car_high = car_high_inc;
                seg_end    = (car_cnt_inc == '0) && !car_high_inc &&
                             (elapsed_inc >= {1'b0, seg_len});
            end else begin
                seg_end = (elapsed_inc >= {1'b0, seg_len});
            end
            if (seg_end) begin
                n_elapsed  = '0;
                n_car_cnt  = '0;
                n_car_high = 1'b0;
                case (r_phase)
                    PH_LEAD_MARK: begin
                        if (i_cfg.leader_space_us != '0) begin
                            n_phase = PH_LEAD_SPACE;
                        end else begin
                            jump = 1'b1;
                        end
                    end
                    PH_BIT_MARK: begin
                        if (cur_space != '0) begin
                            n_phase = PH_BIT_SPACE;
                        end else begin
                            jump = 1'b1;
                        end
                    end
                    PH_LEAD_SPACE, PH_BIT_SPACE: begin
                        jump = 1'b1;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
        if (jump) begin
            if (srch_found) begin
                n_pos   = srch_pos;
                n_rest  = srch_rest;
                n_phase = (found_mark != '0) ? PH_BIT_MARK : PH_BIT_SPACE;
            end else begin
                n_phase = PH_IDLE;
            end
        end
        n_res.pin_level  = pin;
        n_res.busy_res   = (n_phase != PH_IDLE);
        n_res.frame_done = jump && !srch_found;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_phase     <= n_phase;
                r_data      <= n_data;
                r_rest      <= n_rest;
                r_pos       <= n_pos;
                r_elapsed   <= n_elapsed;
                r_car_cnt   <= n_car_cnt;
                r_car_high  <= n_car_high;
                r_res       <= n_res;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_done_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && n_res.frame_done) |=> (r_phase == PH_IDLE))
        else $error("frame_done reported while the frame continues");

    a_segment_entry_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && (n_phase != r_phase)) |=>
        ((r_elapsed == '0) && (r_car_cnt == '0) && !r_car_high))
        else $error("segment entered with stale timing counters");

    a_rest_below_current: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_BIT_MARK) || (r_phase == PH_BIT_SPACE)) |->
        ((r_rest >> r_pos) == '0))
        else $error("pending bit mask overlaps the current bit");

    a_busy_matches_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> (r_out_valid && (r_res.busy_res == (r_phase != PH_IDLE))))
        else $error("busy flag disagrees with sequencer phase");

endmodule

`default_nettype wire

>>> tb/ir_pulse_distance_transmitter_tb.sv
// ============================================================================
// ir_pulse_distance_transmitter_tb
// Self-checking bench for the infrared pulse-distance transmitter. Requests
// (microsecond ticks and frame starts) are sent over the valid/ready input
// channel with random gaps. A scoreboard that models the leader, bit marks,
// bit spaces and carrier predicts the pin level, busy flag and frame end for
// every request. Each returned result is compared field by field. Directed
// frames cover the reset timing, timing changes in the middle of a frame,
// zero-length segments, saturated bit counts, starts while busy and the
// widest timing values. Random timing settings and random frames follow.
// ============================================================================
`default_nettype none

module ir_pulse_distance_transmitter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_BITS      = 64;
    localparam int LIMIT_CYCLES  = 40_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 55;
    localparam int STEADY_PHASE  = 3;
    localparam int IDLE_PERCENT  = 38;
    localparam int PROBE_TICKS   = 30;
    localparam int WIDE_TICKS    = 40;

    localparam logic [irpdt_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    class pulse_frame_scoreboard;

        typedef enum logic [2:0] {
            SEG_IDLE,
            SEG_LEAD_MARK,
            SEG_LEAD_SPACE,
            SEG_BIT_MARK,
            SEG_BIT_SPACE
        } t_segment;

        irpdt_pkg::t_cfg                 timing;
        t_segment                        segment;
        logic [irpdt_pkg::COUNT_W-1:0]   bits_left;
        logic [irpdt_pkg::FRAME_W-1:0]   shift_bits;
        logic [irpdt_pkg::ELAPSED_W-1:0] elapsed;
        logic [irpdt_pkg::HALF_W-1:0]    carrier_count;
        logic                            high_half;
        irpdt_pkg::t_out_res             pin_levels_due[$];
        int                              mismatches;
        int                              requests;
        int                              results;
        int                              frames_started;
        int                              frames_ended;

        function new();
            timing         = irpdt_pkg::CFG_RESET;
            segment        = SEG_IDLE;
            bits_left      = '0;
            shift_bits     = '0;
            elapsed        = '0;
            carrier_count  = '0;
            high_half      = 1'b0;
            mismatches     = 0;
            requests       = 0;
            results        = 0;
            frames_started = 0;
            frames_ended   = 0;
        endfunction

        function void load_timing(irpdt_pkg::t_cfg t);
            timing = t;
        endfunction

        function bit busy();
            return segment != SEG_IDLE;
        endfunction

        function int pending();
            return pin_levels_due.size();
        endfunction

        function logic [irpdt_pkg::DUR_W-1:0] segment_length();
            case (segment)
                SEG_LEAD_MARK:  return timing.leader_mark_us;
                SEG_LEAD_SPACE: return timing.leader_space_us;
                SEG_BIT_MARK:   return shift_bits[irpdt_pkg::FRAME_W-1] ? timing.one_mark_us
                                                                        : timing.zero_mark_us;
                SEG_BIT_SPACE:  return shift_bits[irpdt_pkg::FRAME_W-1] ? timing.one_space_us
                                                                        : timing.zero_space_us;
                default:        return '0;
            endcase
        endfunction

        function bit segment_over();
            logic [irpdt_pkg::ELAPSED_W-1:0] len;
            len = {1'b0, segment_length()};
            if (segment == SEG_LEAD_MARK || segment == SEG_BIT_MARK) begin
                return carrier_count == '0 && !high_half && elapsed >= len;
            end
            return elapsed >= len;
        endfunction

        function void next_segment();
            elapsed       = '0;
            carrier_count = '0;
            high_half     = 1'b0;
            case (segment)
                SEG_LEAD_MARK: begin
                    segment = SEG_LEAD_SPACE;
                end
                SEG_LEAD_SPACE: begin
                    segment = (bits_left != '0) ? SEG_BIT_MARK : SEG_IDLE;
                end
                SEG_BIT_MARK: begin
                    segment = SEG_BIT_SPACE;
                end
                SEG_BIT_SPACE: begin
                    shift_bits = shift_bits << 1;
                    if (bits_left != '0) begin
                        bits_left = bits_left - 1'b1;
                    end
                    segment = (bits_left != '0) ? SEG_BIT_MARK : SEG_IDLE;
                end
                default: begin
                    segment = SEG_IDLE;
                end
            endcase
        endfunction

        function bit settle();
            while (segment != SEG_IDLE && segment_over()) begin
                next_segment();
            end
            return segment == SEG_IDLE;
        endfunction

        function irpdt_pkg::t_out_res advance_pin(irpdt_pkg::t_in_req r);
            irpdt_pkg::t_out_res          res;
            logic [irpdt_pkg::HALF_W-1:0] half;
            res.pin_level  = 1'b1;
            res.busy_res   = 1'b0;
            res.frame_done = 1'b0;
            if (r.kind == irpdt_pkg::KIND_START) begin
                if (segment == SEG_IDLE) begin
                    bits_left      = (r.bit_count > MAX_BITS) ?
                                     irpdt_pkg::COUNT_W'(MAX_BITS) : r.bit_count;
                    shift_bits     = r.frame_bits;
                    segment        = SEG_LEAD_MARK;
                    elapsed        = '0;
                    carrier_count  = '0;
                    high_half      = 1'b0;
                    frames_started++;
                    res.frame_done = settle();
                end
            end else if (segment != SEG_IDLE) begin
                if (segment == SEG_LEAD_MARK || segment == SEG_BIT_MARK) begin
                    half          = (timing.carrier_half_us != '0) ?
                                    timing.carrier_half_us : irpdt_pkg::HALF_W'(1);
                    res.pin_level = high_half;
                    carrier_count = carrier_count + 1'b1;
                    if (carrier_count >= half) begin
                        carrier_count = '0;
                        high_half     = ~high_half;
                    end
                end
                elapsed        = elapsed + 1'b1;
                res.frame_done = settle();
            end
            res.busy_res = segment != SEG_IDLE;
            if (res.frame_done) begin
                frames_ended++;
            end
            return res;
        endfunction

        function void note_request(irpdt_pkg::t_in_req r);
            requests++;
            pin_levels_due.push_back(advance_pin(r));
        endfunction

        function void compare_field(string field, logic want, logic got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR at %0t: result %0d %s expected %b, got %b",
                             $time, results, field, want, got);
                end
            end
        endfunction

        function void check_result(irpdt_pkg::t_out_res got);
            irpdt_pkg::t_out_res want;
            if (pin_levels_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR at %0t: result %b arrived with no request pending",
                             $time, got);
                end
                return;
            end
            want = pin_levels_due.pop_front();
            compare_field("pin_level", want.pin_level, got.pin_level);
            compare_field("busy_res", want.busy_res, got.busy_res);
            compare_field("frame_done", want.frame_done, got.frame_done);
            results++;
        endfunction

    endclass

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             cfg_wr_en = 1'b0;
    logic [irpdt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [irpdt_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                             in_valid  = 1'b0;
    logic                             in_ready;
    irpdt_pkg::t_in_req               in_req    = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    irpdt_pkg::t_out_res              out_res;
    bit                               steady    = 1'b0;
    int                               cycles    = 0;
    int                               settings  = 0;

    pulse_frame_scoreboard tx_check;

    ir_pulse_distance_transmitter #(
        .MAX_BITS(MAX_BITS)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_res   (out_res)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk) begin
        out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            tx_check.check_result(out_res);
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycles, tx_check.pending());
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [irpdt_pkg::FRAME_W-1:0] random_frame();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [irpdt_pkg::DUR_W-1:0] short_duration();
        return ($urandom_range(0, 4) == 0) ? '0 : irpdt_pkg::DUR_W'($urandom_range(1, 9));
    endfunction

    function automatic irpdt_pkg::t_cfg random_timing();
        irpdt_pkg::t_cfg t;
        t.carrier_half_us = irpdt_pkg::HALF_W'($urandom_range(0, 3));
        t.leader_mark_us  = short_duration();
        t.leader_space_us = short_duration();
        t.one_mark_us     = short_duration();
        t.one_space_us    = short_duration();
        t.zero_mark_us    = short_duration();
        t.zero_space_us   = short_duration();
        return t;
    endfunction

    task automatic send_item(irpdt_pkg::t_in_req r);
        if (!steady) begin
            while ($urandom_range(0, 99) < IDLE_PERCENT) begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        end
        in_valid <= 1'b1;
        in_req   <= r;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        tx_check.note_request(r);
        @(negedge clk);
    endtask

    task automatic send_tick();
        irpdt_pkg::t_in_req r;
        r.kind       = irpdt_pkg::KIND_TICK;
        r.frame_bits = random_frame();
        r.bit_count  = irpdt_pkg::COUNT_W'($urandom_range(0, 127));
        send_item(r);
    endtask

    task automatic send_start(logic [irpdt_pkg::FRAME_W-1:0] frame,
                              logic [irpdt_pkg::COUNT_W-1:0] count);
        irpdt_pkg::t_in_req r;
        r.kind       = irpdt_pkg::KIND_START;
        r.frame_bits = frame;
        r.bit_count  = count;
        send_item(r);
    endtask

    task automatic finish_frame();
        while (tx_check.busy()) begin
            send_tick();
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (tx_check.pending() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apply_config(irpdt_pkg::t_cfg c);
        irpdt_pkg::t_cfg_idx idx;
        for (int k = irpdt_pkg::CFG_CARRIER_HALF; k <= irpdt_pkg::CFG_ZERO_SPACE; k++) begin
            idx       = irpdt_pkg::t_cfg_idx'(k);
            cfg_wr_en <= 1'b1;
            cfg_index <= idx;
            case (idx)
                irpdt_pkg::CFG_CARRIER_HALF: cfg_data <= {8'($urandom_range(0, 255)),
                                                          c.carrier_half_us};
                irpdt_pkg::CFG_LEADER_MARK:  cfg_data <= c.leader_mark_us;
                irpdt_pkg::CFG_LEADER_SPACE: cfg_data <= c.leader_space_us;
                irpdt_pkg::CFG_ONE_MARK:     cfg_data <= c.one_mark_us;
                irpdt_pkg::CFG_ONE_SPACE:    cfg_data <= c.one_space_us;
                irpdt_pkg::CFG_ZERO_MARK:    cfg_data <= c.zero_mark_us;
                irpdt_pkg::CFG_ZERO_SPACE:   cfg_data <= c.zero_space_us;
                default:                     cfg_data <= '0;
            endcase
            @(negedge clk);
        end
        // Writes to the spare index must leave every timing register alone.
        cfg_index <= CFG_UNUSED_IDX;
        cfg_data  <= irpdt_pkg::CFG_DATA_W'($urandom);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        tx_check.load_timing(c);
        settings++;
    endtask

    task automatic run_random_phase(int budget);
        int sent;
        int pick;
        sent = 0;
        while (sent < budget) begin
            if ($urandom_range(0, 3) == 0) begin
                send_tick();
                sent++;
            end
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                send_start(random_frame(), '0);
            end else if (pick < 8) begin
                send_start(random_frame(), irpdt_pkg::COUNT_W'($urandom_range(65, 127)));
            end else begin
                send_start(random_frame(), irpdt_pkg::COUNT_W'($urandom_range(1, 8)));
            end
            sent++;
            while (tx_check.busy()) begin
                if ($urandom_range(0, 99) < 8) begin
                    send_start(random_frame(), irpdt_pkg::COUNT_W'($urandom_range(0, 127)));
                end else begin
                    send_tick();
                end
                sent++;
            end
        end
    endtask

    initial begin
        irpdt_pkg::t_cfg timing;
        tx_check = new();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset timing: the first carrier periods of the leader, with a start
        // request while busy, then shorter timing takes over mid-frame.
        send_tick();
        send_tick();
        send_start(random_frame(), irpdt_pkg::COUNT_W'(5));
        repeat (PROBE_TICKS) send_tick();
        send_start(random_frame(), '0);
        repeat (PROBE_TICKS) send_tick();
        wait_drained();
        timing = '{carrier_half_us: 8'd2, leader_mark_us: 16'd3, leader_space_us: 16'd4,
                   one_mark_us: 16'd5, one_space_us: 16'd3, zero_mark_us: 16'd2,
                   zero_space_us: 16'd1};
        apply_config(timing);
        finish_frame();
        send_tick();
        wait_drained();

        timing = '{carrier_half_us: 8'd0, leader_mark_us: 16'd1, leader_space_us: 16'd2,
                   one_mark_us: 16'd3, one_space_us: 16'd2, zero_mark_us: 16'd0,
                   zero_space_us: 16'd1};
        apply_config(timing);
        send_start(64'hB4C3_5A0F_0000_0001, irpdt_pkg::COUNT_W'(8));
        finish_frame();
        send_start('0, irpdt_pkg::COUNT_W'(127));
        finish_frame();
        send_start('1, irpdt_pkg::COUNT_W'(2));
        finish_frame();
        wait_drained();

        timing = '{carrier_half_us: 8'd255, leader_mark_us: 16'd0, leader_space_us: 16'd0,
                   one_mark_us: 16'd0, one_space_us: 16'd0, zero_mark_us: 16'd0,
                   zero_space_us: 16'd0};
        apply_config(timing);
        send_start(random_frame(), irpdt_pkg::COUNT_W'(MAX_BITS));
        send_start(random_frame(), '0);
        send_tick();
        wait_drained();

        steady = 1'b1;
        timing = '{carrier_half_us: 8'd255, leader_mark_us: 16'hFFFF,
                   leader_space_us: 16'hFFFF, one_mark_us: 16'hFFFF,
                   one_space_us: 16'hFFFF, zero_mark_us: 16'hFFFF,
                   zero_space_us: 16'hFFFF};
        apply_config(timing);
        send_start(random_frame(), '0);
        repeat (WIDE_TICKS) send_tick();
        send_start(random_frame(), irpdt_pkg::COUNT_W'(3));
        wait_drained();
        timing = '{carrier_half_us: 8'd1, leader_mark_us: 16'd2, leader_space_us: 16'd3,
                   one_mark_us: 16'd2, one_space_us: 16'd2, zero_mark_us: 16'd1,
                   zero_space_us: 16'd1};
        apply_config(timing);
        finish_frame();
        wait_drained();
        steady = 1'b0;

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            steady = (p == STEADY_PHASE);
            apply_config(random_timing());
            run_random_phase(PHASE_ITEMS);
            wait_drained();
        end
        steady = 1'b0;

        $display("Run covered %0d requests and %0d results over %0d timing settings.",
                 tx_check.requests, tx_check.results, settings);
        $display("Frames started: %0d, frames ended: %0d, field errors: %0d.",
                 tx_check.frames_started, tx_check.frames_ended, tx_check.mismatches);
        if (tx_check.mismatches == 0 && tx_check.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
